// ----- design/odo_pkg.sv -----
// Shared types, constants and tables for the differential-drive odometry block.
`default_nettype none
package odo_pkg;

    // Default build parameters.
    localparam int ANGLE_BITS_DEF  = 32;
    localparam int TRIG_STAGES_DEF = 16;
    localparam int TRIG_MAX        = 24;

    // Register map widths.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_BLEND_ALPHA = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_USE_GYRO    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_AXLE    = 2'd2;

    // Register reset values.
    localparam logic [16:0] ALPHA_RESET = 17'd0;
    localparam logic [16:0] ALPHA_ONE   = 17'd65536;
    localparam logic        GYRO_RESET  = 1'b1;
    localparam logic [23:0] INV_RESET   = 24'd131072;

    // CORDIC gain in Q2.30 and the reciprocal of two pi in Q0.32.
    localparam logic [33:0] CORDIC_GAIN_Q30 = 34'd652032874;
    localparam logic [29:0] INV_TWO_PI_Q32  = 30'd683565276;

    // Width of the CORDIC datapath words.
    localparam int CW = 34;

    // Arctangent table in binary angle units of 2^32 per turn.
    localparam logic [31:0] ATAN_TAB [TRIG_MAX] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // One input transaction.
    typedef struct packed {
        logic signed [23:0] left_speed;
        logic signed [23:0] right_speed;
        logic signed [23:0] gyro_rate;
        logic        [19:0] elapsed;
    } in_item_t;

    // One result transaction.
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [15:0] heading;
        logic signed [23:0] lin_vel;
        logic signed [23:0] ang_vel;
    } out_item_t;

    // Word passed from one CORDIC cell to the next.
    typedef struct packed {
        logic                 valid;
        logic                 flip;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cordic_t;

endpackage
`default_nettype wire

// ----- design/diff_drive_odometry.sv -----
// Top level of the differential-drive dead-reckoning odometry block.
//
// Input transactions (in_data) carry wheel speeds, gyro rate and elapsed
// time; they are taken when in_valid is high and in_stall is low. Result
// transactions (out_data) leave through an output register under
// out_valid/out_stall. The very first input after reset only primes the
// block and returns nothing; each later input returns one result.
// The heading goes through a row of TRIG_STAGES CORDIC cells while a single
// shared 34x34 multiplier works through the encoder-rate, blend and
// heading-step products, then four more products give the position steps.
// One item is in work at a time, so in_stall stays high from the acceptance
// of an input that returns a result until that result is loaded into the
// output register; the block takes no new input before then. A pending
// result held by out_stall does not stop a new input from being taken, but the
// next result waits until the register is free. Reset clears the position,
// heading and prime flag and loads the register defaults; configuration writes
// on cfg_we are taken in any cycle and must be made while the block is idle.
`default_nettype none
module diff_drive_odometry #(
    parameter int ANGLE_BITS  = odo_pkg::ANGLE_BITS_DEF,
    parameter int TRIG_STAGES = odo_pkg::TRIG_STAGES_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_stall,
    input  odo_pkg::in_item_t                  in_data,
    output logic                               out_valid,
    input  wire                                out_stall,
    output odo_pkg::out_item_t                 out_data,
    input  wire                                cfg_we,
    input  wire [odo_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire [odo_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import odo_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_ENC, S_BA, S_BB, S_BC, S_HD, S_HA, S_HB, S_HC, S_HE,
        S_WAIT, S_XA, S_XB, S_XC, S_XD, S_XE, S_DONE
    } state_t;

    state_t                 state_reg;
    logic [16:0]            alpha_reg;
    logic                   gyro_reg;
    logic [23:0]            inv_reg;
    logic                   primed_reg;
    logic signed [31:0]     acc_x_reg;
    logic signed [31:0]     acc_y_reg;
    logic [ANGLE_BITS-1:0]  acc_head_reg;
    in_item_t               item_reg;
    logic signed [67:0]     mul_reg;
    logic signed [23:0]     wenc_reg;
    logic signed [41:0]     pb_reg;
    logic signed [23:0]     dth_reg;
    logic [43:0]            m_reg;
    logic                   neg_reg;
    logic [51:0]            a_reg;
    logic [ANGLE_BITS-1:0]  step_reg;
    logic signed [31:0]     cs_reg;
    logic signed [31:0]     sn_reg;
    logic                   trig_reg;
    logic signed [25:0]     vcs_reg;
    logic signed [25:0]     vsn_reg;
    logic signed [29:0]     dx_reg;
    logic signed [29:0]     dy_reg;
    logic                   out_valid_reg;
    out_item_t              out_reg;

    logic                   in_take;
    logic signed [24:0]     diff;
    logic signed [24:0]     sum;
    logic signed [23:0]     vel;
    logic [16:0]            alpha_c;
    logic [16:0]            alpha_n;
    logic signed [33:0]     mul_a;
    logic signed [33:0]     mul_b;
    logic signed [23:0]     wenc_sat;
    logic signed [41:0]     blend;
    logic [43:0]            mag;
    logic [52:0]            tsum;
    logic [42:0]            rr;
    logic [42:0]            scaled;
    logic [ANGLE_BITS-1:0]  step_mag;
    logic [31:0]            ang32;
    logic                   flip;
    logic [31:0]            zang;
    cordic_t                row_in;
    cordic_t                row_out;
    logic signed [32:0]     nx_sum;
    logic signed [32:0]     ny_sum;
    logic signed [31:0]     nx_sat;
    logic signed [31:0]     ny_sat;
    logic                   out_free;

    assign in_take   = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Speed and wheel difference from the held transaction.
    assign sum  = {item_reg.left_speed[23], item_reg.left_speed}
                + {item_reg.right_speed[23], item_reg.right_speed};
    assign diff = {item_reg.right_speed[23], item_reg.right_speed}
                - {item_reg.left_speed[23], item_reg.left_speed};
    assign vel  = sum[24:1];

    assign alpha_c = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign alpha_n = ALPHA_ONE - alpha_c;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_ENC:
            begin
                mul_a = {{9{diff[24]}}, diff};
                mul_b = $signed({10'b0, inv_reg});
            end
            S_BA:
            begin
                mul_a = $signed({17'b0, alpha_n});
                mul_b = {{10{item_reg.gyro_rate[23]}}, item_reg.gyro_rate};
            end
            S_BB:
            begin
                mul_a = $signed({17'b0, alpha_c});
                mul_b = {{10{wenc_reg[23]}}, wenc_reg};
            end
            S_HD:
            begin
                mul_a = {{10{dth_reg[23]}}, dth_reg};
                mul_b = $signed({14'b0, item_reg.elapsed});
            end
            S_HB:
            begin
                mul_a = $signed({12'b0, m_reg[43:22]});
                mul_b = $signed({4'b0, INV_TWO_PI_Q32});
            end
            S_HC:
            begin
                mul_a = $signed({12'b0, m_reg[21:0]});
                mul_b = $signed({4'b0, INV_TWO_PI_Q32});
            end
            S_XA:
            begin
                mul_a = {{10{vel[23]}}, vel};
                mul_b = {{2{cs_reg[31]}}, cs_reg};
            end
            S_XB:
            begin
                mul_a = {{10{vel[23]}}, vel};
                mul_b = {{2{sn_reg[31]}}, sn_reg};
            end
            S_XC:
            begin
                mul_a = {{8{vcs_reg[25]}}, vcs_reg};
                mul_b = $signed({14'b0, item_reg.elapsed});
            end
            S_XD:
            begin
                mul_a = {{8{vsn_reg[25]}}, vsn_reg};
                mul_b = $signed({14'b0, item_reg.elapsed});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Encoder rate saturated to 24 bits.
    always_comb
    begin
        if ((mul_reg[67:39] == '0) || (mul_reg[67:39] == '1))
        begin
            wenc_sat = mul_reg[39:16];
        end
        else if (mul_reg[67])
        begin
            wenc_sat = 24'sh800000;
        end
        else
        begin
            wenc_sat = 24'sh7FFFFF;
        end
    end

    assign blend = $signed(mul_reg[41:0]) + pb_reg;
    assign mag   = mul_reg[43] ? (44'd0 - mul_reg[43:0]) : mul_reg[43:0];

    // Heading step: magnitude times one over two pi, from two partial products.
    assign tsum     = {21'b0, a_reg[9:0], 22'b0} + {1'b0, mul_reg[51:0]};
    assign rr       = {1'b0, a_reg[51:10]} + {22'b0, tsum[52:32]};
    assign scaled   = rr >> (32 - ANGLE_BITS);
    assign step_mag = scaled[ANGLE_BITS-1:0];

    // CORDIC launch from the heading held before this transaction.
    assign ang32 = 32'(acc_head_reg) << (32 - ANGLE_BITS);
    assign flip  = ang32[31] ^ ang32[30];
    assign zang  = flip ? (ang32 ^ 32'h8000_0000) : ang32;

    always_comb
    begin
        row_in.valid = in_take && primed_reg;
        row_in.flip  = flip;
        row_in.x     = $signed(CORDIC_GAIN_Q30);
        row_in.y     = '0;
        row_in.z     = {{2{zang[31]}}, zang};
    end

    odo_cordic_row #(.TRIG_STAGES(TRIG_STAGES)) u_row (
        .clk  (clk),
        .rst_n(rst_n),
        .din  (row_in),
        .dout (row_out)
    );

    // Saturating position update.
    assign nx_sum = {acc_x_reg[31], acc_x_reg} + {{3{dx_reg[29]}}, dx_reg};
    assign ny_sum = {acc_y_reg[31], acc_y_reg} + {{3{dy_reg[29]}}, dy_reg};
    assign nx_sat = (nx_sum[32] != nx_sum[31]) ?
                    (nx_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : nx_sum[31:0];
    assign ny_sat = (ny_sum[32] != ny_sum[31]) ?
                    (ny_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : ny_sum[31:0];

    // Control state, accumulators and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            alpha_reg     <= ALPHA_RESET;
            gyro_reg      <= GYRO_RESET;
            inv_reg       <= INV_RESET;
            primed_reg    <= 1'b0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            acc_head_reg  <= '0;
            trig_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BLEND_ALPHA: alpha_reg <= cfg_data[16:0];
                    REG_USE_GYRO:    gyro_reg  <= cfg_data[0];
                    REG_INV_AXLE:    inv_reg   <= cfg_data[23:0];
                    default:         ;
                endcase
            end

            // The output register fills at the end of a transaction and empties
            // when the receiver takes it.
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // Marks cosine and sine ready for the transaction in work.
            if (in_take)
            begin
                trig_reg <= 1'b0;
            end
            else if (row_out.valid)
            begin
                trig_reg <= 1'b1;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        primed_reg <= 1'b1;
                        if (primed_reg)
                        begin
                            state_reg <= S_ENC;
                        end
                    end
                end
                S_ENC:  state_reg <= S_BA;
                S_BA:   state_reg <= S_BB;
                S_BB:   state_reg <= S_BC;
                S_BC:   state_reg <= S_HD;
                S_HD:   state_reg <= S_HA;
                S_HA:   state_reg <= S_HB;
                S_HB:   state_reg <= S_HC;
                S_HC:   state_reg <= S_HE;
                S_HE:   state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (trig_reg)
                    begin
                        state_reg <= S_XA;
                    end
                end
                S_XA:   state_reg <= S_XB;
                S_XB:   state_reg <= S_XC;
                S_XC:   state_reg <= S_XD;
                S_XD:   state_reg <= S_XE;
                S_XE:   state_reg <= S_DONE;
                S_DONE:
                begin
                    if (out_free)
                    begin
                        acc_x_reg     <= nx_sat;
                        acc_y_reg     <= ny_sat;
                        acc_head_reg  <= acc_head_reg + step_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
        if (in_take)
        begin
            item_reg <= in_data;
        end
        if (row_out.valid)
        begin
            cs_reg <= row_out.flip ? -row_out.x[31:0] : row_out.x[31:0];
            sn_reg <= row_out.flip ? -row_out.y[31:0] : row_out.y[31:0];
        end
        case (state_reg)
            S_BA: wenc_reg <= wenc_sat;
            S_BB: pb_reg   <= mul_reg[41:0];
            S_BC: dth_reg  <= gyro_reg ? blend[39:16] : wenc_reg;
            S_HA:
            begin
                m_reg   <= mag;
                neg_reg <= mul_reg[43];
            end
            S_HC: a_reg <= mul_reg[51:0];
            S_HE: step_reg <= neg_reg ? ('0 - step_mag) : step_mag;
            S_XB: vcs_reg <= mul_reg[55:30];
            S_XC: vsn_reg <= mul_reg[55:30];
            S_XD: dx_reg  <= mul_reg[45:16];
            S_XE: dy_reg  <= mul_reg[45:16];
            S_DONE:
            begin
                if (out_free)
                begin
                    out_reg.pos_x   <= nx_sat;
                    out_reg.pos_y   <= ny_sat;
                    out_reg.heading <= 16'((acc_head_reg + step_reg) >> (ANGLE_BITS - 16));
                    out_reg.lin_vel <= (item_reg.elapsed == '0) ? '0 : vel;
                    out_reg.ang_vel <= (item_reg.elapsed == '0) ? '0 : dth_reg;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ----- design/odo_cordic_cell.sv -----
// One rotation cell of the CORDIC row.
`default_nettype none
module odo_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire              clk,
    input  wire              rst_n,
    input  odo_pkg::cordic_t din,
    output odo_pkg::cordic_t dout
);
    import odo_pkg::*;

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] atan_w;
    cordic_t              dout_reg;

    assign xs     = din.x >>> STAGE;
    assign ys     = din.y >>> STAGE;
    assign atan_w = $signed({2'b00, ATAN_TAB[STAGE]});

    // Rotate toward zero residual angle; the whole word clears under reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_reg <= '0;
        end
        else
        begin
            dout_reg.valid <= din.valid;
            dout_reg.flip  <= din.flip;
            if (!din.z[CW-1])
            begin
                dout_reg.x <= din.x - ys;
                dout_reg.y <= din.y + xs;
                dout_reg.z <= din.z - atan_w;
            end
            else
            begin
                dout_reg.x <= din.x + ys;
                dout_reg.y <= din.y - xs;
                dout_reg.z <= din.z + atan_w;
            end
        end
    end

    assign dout = dout_reg;

endmodule
`default_nettype wire

// ----- design/odo_cordic_row.sv -----
// Row of CORDIC cells that turns a heading into cosine and sine.
`default_nettype none
module odo_cordic_row #(
    parameter int TRIG_STAGES = odo_pkg::TRIG_STAGES_DEF
) (
    input  wire              clk,
    input  wire              rst_n,
    input  odo_pkg::cordic_t din,
    output odo_pkg::cordic_t dout
);
    import odo_pkg::*;

    cordic_t link [TRIG_STAGES+1];

    assign link[0] = din;

    // Each cell hands its rotated vector to the next every cycle.
    for (genvar i = 0; i < TRIG_STAGES; i++)
    begin : g_cell
        odo_cordic_cell #(.STAGE(i)) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .din  (link[i]),
            .dout (link[i+1])
        );
    end

    assign dout = link[TRIG_STAGES];

endmodule
`default_nettype wire

// ----- design/odo_checker.sv -----
// Port-level checks for the odometry block and their binding.
`default_nettype none
module odo_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 in_valid,
    input wire                 in_stall,
    input wire                 out_valid,
    input wire                 out_stall,
    input odo_pkg::out_item_t  out_data
);
    import odo_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // A new result only appears at the end of a busy period.
    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without work in progress");

    // Once work starts, the busy state does not end straight away.
    a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 in_stall |=> in_stall)
        else $error("work finished too early");

endmodule

bind diff_drive_odometry odo_checker u_odo_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
);
`default_nettype wire

// ----- bench/diff_drive_odometry_test.sv -----
// Self-checking testbench for the differential-drive odometry block.
`default_nettype none
module diff_drive_odometry_test;
    import odo_pkg::*;

    localparam int  DRAIN_CYCLES = 48;
    localparam longint CYCLE_LIMIT = 1500000;
    localparam longint GAIN_Q30 = 652032874;
    localparam longint RECIP_TWO_PI = 683565276;

    // An index past the end of the register map.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_data;
    logic out_valid;
    logic out_stall;
    out_item_t out_data;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    diff_drive_odometry dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Shadow of the block's registers and dead-reckoning state.
    logic [16:0] sh_alpha;
    logic        sh_gyro_on;
    logic [23:0] sh_inv_axle;
    logic signed [31:0] sh_x;
    logic signed [31:0] sh_y;
    logic [31:0] sh_heading;
    bit          sh_primed;

    out_item_t pose_queue[$];
    int  errors;
    longint cycles;
    bit  quiet;

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic longint sat_to(longint v, int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // Rotation of the unit vector by the heading, giving cos and sin in Q2.30.
    task automatic cordic_rotate(input logic [31:0] ang, output longint c, output longint s);
        bit flip;
        longint x, y, z, xs, ys;
        logic [31:0] a;
        a = ang;
        flip = 1'b0;
        if (a[31:30] == 2'd1 || a[31:30] == 2'd2)
        begin
            a = a - 32'h8000_0000;
            flip = 1'b1;
        end
        z = longint'($signed(a));
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < TRIG_STAGES_DEF; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_TAB[i]);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_TAB[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // Turns a Q.32 radian step into binary angle units, truncated toward zero.
    function automatic longint heading_step(longint prod);
        bit neg;
        longint unsigned m, a, b, r;
        neg = prod < 0;
        m = neg ? longint'(-prod) : prod;
        a = (m >> 22) * RECIP_TWO_PI;
        b = (m & 64'h3F_FFFF) * RECIP_TWO_PI;
        r = (a >> 10) + ((((a & 64'd1023) << 22) + b) >> 32);
        return neg ? -longint'(r) : longint'(r);
    endfunction

    // Advances the shadow pose by one accepted transaction.
    task automatic advance_pose(input in_item_t it);
        longint l, r, g, dt, v, wenc, dth, alpha, cs, sn, dx, dy;
        out_item_t res;
        l = longint'(it.left_speed);
        r = longint'(it.right_speed);
        g = longint'(it.gyro_rate);
        dt = longint'(it.elapsed);
        if (!sh_primed)
        begin
            sh_primed = 1'b1;
            return;
        end
        v = (l + r) >>> 1;
        wenc = sat_to(((r - l) * longint'(sh_inv_axle)) >>> 16, 24);
        if (sh_gyro_on)
        begin
            alpha = (sh_alpha > 17'd65536) ? 65536 : longint'(sh_alpha);
            dth = (alpha * wenc + (65536 - alpha) * g) >>> 16;
        end
        else
            dth = wenc;
        cordic_rotate(sh_heading, cs, sn);
        dx = (((v * cs) >>> 30) * dt) >>> 16;
        dy = (((v * sn) >>> 30) * dt) >>> 16;
        sh_x = 32'(sat_to(longint'(sh_x) + dx, 32));
        sh_y = 32'(sat_to(longint'(sh_y) + dy, 32));
        sh_heading = sh_heading + 32'(heading_step(dth * dt));
        res.pos_x = sh_x;
        res.pos_y = sh_y;
        res.heading = sh_heading[31:16];
        res.lin_vel = (dt == 0) ? 24'd0 : 24'(v);
        res.ang_vel = (dt == 0) ? 24'd0 : 24'(dth);
        pose_queue.push_back(res);
    endtask

    function automatic int gap_len();
        int p;
        if (quiet)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side back-pressure.
    int stall_left;
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
        else
        begin
            stall_left <= gap_len();
            out_stall <= (stall_left == 0) && !quiet && ($urandom_range(0, 2) == 0);
        end
    end

    // Compares each accepted result transaction with the oldest predicted pose.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pose_queue.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result %h", $time, out_data);
            end
            else
            begin
                want = pose_queue.pop_front();
                if (out_data.pos_x !== want.pos_x)
                begin
                    errors++;
                    $display("%0t pos_x exp %0d got %0d", $time, want.pos_x, out_data.pos_x);
                end
                if (out_data.pos_y !== want.pos_y)
                begin
                    errors++;
                    $display("%0t pos_y exp %0d got %0d", $time, want.pos_y, out_data.pos_y);
                end
                if (out_data.heading !== want.heading)
                begin
                    errors++;
                    $display("%0t heading exp %0d got %0d", $time, want.heading,
                             out_data.heading);
                end
                if (out_data.lin_vel !== want.lin_vel)
                begin
                    errors++;
                    $display("%0t lin_vel exp %0d got %0d", $time, want.lin_vel,
                             out_data.lin_vel);
                end
                if (out_data.ang_vel !== want.ang_vel)
                begin
                    errors++;
                    $display("%0t ang_vel exp %0d got %0d", $time, want.ang_vel,
                             out_data.ang_vel);
                end
            end
        end
    end

    // Sends one input transaction; called and returns at a rising edge.
    task automatic send_motion(input logic [23:0] l, input logic [23:0] r,
                               input logic [23:0] g, input logic [19:0] dt);
        int gap;
        in_item_t it;
        gap = gap_len();
        it.left_speed = l;
        it.right_speed = r;
        it.gyro_rate = g;
        it.elapsed = dt;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (in_stall);
        advance_pose(it);
    endtask

    // Drops valid and waits until every predicted pose has arrived.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pose_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [23:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_BLEND_ALPHA)
            sh_alpha = val[16:0];
        else if (idx == REG_USE_GYRO)
            sh_gyro_on = val[0];
        else if (idx == REG_INV_AXLE)
            sh_inv_axle = val;
    endtask

    // Field extremes, zero elapsed time, encoder rate saturation and register writes.
    task automatic test_directed();
        send_motion(24'd65536, 24'd65536, 24'd0, 20'd65536);
        send_motion(24'd0, 24'd0, 24'd0, 20'd0);
        send_motion(24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, 20'hF_FFFF);
        send_motion(24'h80_0000, 24'h80_0000, 24'h80_0000, 20'hF_FFFF);
        send_motion(24'h80_0000, 24'h7F_FFFF, 24'd0, 20'd1000);
        send_motion(24'h7F_FFFF, 24'h80_0000, 24'd0, 20'd1000);
        send_motion(24'h7F_FFFF, 24'h00_0000, 24'h123456, 20'd0);
        send_motion(24'h010000, 24'h030000, 24'hFF0000, 20'd4096);
        wait_idle();
        write_reg(REG_USE_GYRO, 24'd0);
        write_reg(REG_INV_AXLE, 24'hFF_FFFF);
        send_motion(24'h80_0000, 24'h7F_FFFF, 24'd0, 20'd2000);
        send_motion(24'h000100, 24'h000200, 24'h7F_FFFF, 20'd300);
        send_motion(24'h020000, 24'hFE0000, 24'd0, 20'd0);
        wait_idle();
        write_reg(REG_USE_GYRO, 24'd1);
        write_reg(REG_BLEND_ALPHA, 24'h1_FFFF);
        write_reg(REG_INV_AXLE, 24'd0);
        write_reg(REG_SPARE, 24'hAB_CDEF);
        send_motion(24'h100000, 24'h300000, 24'h7F_FFFF, 20'd5000);
        send_motion(24'hF00000, 24'h100000, 24'h80_0000, 20'd5000);
        wait_idle();
        write_reg(REG_BLEND_ALPHA, 24'd65536);
        write_reg(REG_INV_AXLE, 24'd131072);
        send_motion(24'h010000, 24'h020000, 24'h7F_FFFF, 20'd8000);
        wait_idle();
    endtask

    // Drives the position to both saturation limits in a straight line along the held heading.
    task automatic test_saturation();
        write_reg(REG_BLEND_ALPHA, 24'd0);
        write_reg(REG_USE_GYRO, 24'd1);
        for (int i = 0; i < 20; i++)
            send_motion(24'h7F_FFFF, 24'h7F_FFFF, 24'd0, 20'hF_FFFF);
        for (int i = 0; i < 40; i++)
            send_motion(24'h80_0000, 24'h80_0000, 24'd0, 20'hF_FFFF);
        wait_idle();
    endtask

    // Random phases, each with its own register setting.
    task automatic test_random();
        logic [23:0] l, r, g;
        logic [19:0] dt;
        int n;
        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase % 4)
                0: write_reg(REG_BLEND_ALPHA, 24'd0);
                1: write_reg(REG_BLEND_ALPHA, 24'd65536);
                2: write_reg(REG_BLEND_ALPHA, 24'($urandom_range(65537, 131071)));
                default: write_reg(REG_BLEND_ALPHA, 24'($urandom_range(0, 65536)));
            endcase
            write_reg(REG_USE_GYRO, 24'($urandom_range(0, 1)));
            case ($urandom_range(0, 3))
                0: write_reg(REG_INV_AXLE, 24'd0);
                1: write_reg(REG_INV_AXLE, 24'hFF_FFFF);
                2: write_reg(REG_INV_AXLE, 24'd131072);
                default: write_reg(REG_INV_AXLE, 24'($urandom));
            endcase
            quiet = (phase % 5 == 3);
            n = 110;
            for (int k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    // Plausible robot motion with random content.
                    l = 24'($signed($urandom_range(0, 262144)) - 131072);
                    r = 24'($signed($urandom_range(0, 262144)) - 131072);
                    g = 24'($signed($urandom_range(0, 524288)) - 262144);
                    dt = ($urandom_range(0, 15) == 0) ? 20'd0 : 20'($urandom_range(1, 70000));
                end
                else
                begin
                    l = 24'($urandom);
                    r = 24'($urandom);
                    g = 24'($urandom);
                    dt = 20'($urandom);
                end
                send_motion(l, r, g, dt);
            end
            wait_idle();
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        quiet = 1'b0;
        sh_alpha = ALPHA_RESET;
        sh_gyro_on = GYRO_RESET;
        sh_inv_axle = INV_RESET;
        sh_x = 0;
        sh_y = 0;
        sh_heading = 0;
        sh_primed = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_saturation();
        test_random();
        wait_idle();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire

// ----- diff_drive_odometry.f -----
design/odo_pkg.sv
design/odo_cordic_cell.sv
design/odo_cordic_row.sv
design/diff_drive_odometry.sv
design/odo_checker.sv
bench/diff_drive_odometry_test.sv
